[hw/rtl/adl_pkg.sv]
// adl_pkg: shared constants and types for the adler-32 checksum block
// no dependencies; used by the interfaces and every module in hw/rtl

package adl_pkg;

  // payload widths
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CSUM_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HALF_W  = 16;

  // number of bytes a data word carries
  localparam int unsigned DATA_BYTES = DATA_W / BYTE_W;

  // default lane count
  localparam int unsigned LANES_DEF = 8;

  // per-lane weighted byte: 4-bit weight times one byte
  localparam int unsigned PROD_W = CNT_W + BYTE_W;

  // modulus, in the widths that compare against it
  localparam logic [HALF_W-1:0] MOD16 = 16'd65521;
  localparam logic [HALF_W:0]   MOD17 = 17'd65521;

  // 2^16 mod 65521, used to fold the upper bits of the high-sum update
  localparam logic [HALF_W:0] FOLD = 17'd15;

  // width of the unreduced high-sum update: b + n*a + weighted sum
  localparam int unsigned WIDE_W = 21;

  // control fields carried down the pipeline with each word
  typedef struct packed {
    logic              first;
    logic              last;
    logic [HALF_W-1:0] seed_lo;
    logic [HALF_W-1:0] seed_hi;
    logic [CNT_W-1:0]  count;
  } ctrl_t;

  // reduce a 16-bit value modulo 65521 (at most one subtraction)
  function automatic logic [HALF_W-1:0] reduce16(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] r;
    r = (v >= MOD16) ? (v - MOD16) : v;
    return r;
  endfunction

endpackage

[hw/rtl/adl_if.sv]
// adl_in_if / adl_out_if: valid/ready channels of the adler-32 block
// depends on adl_pkg for payload widths

interface adl_in_if;
  import adl_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] seed;
  logic [DATA_W-1:0] data_word;
  logic [CNT_W-1:0]  byte_count;
  logic              first;
  logic              last;

  modport source (output valid, seed, data_word, byte_count, first, last, input ready);
  modport sink   (input valid, seed, data_word, byte_count, first, last, output ready);
endinterface

interface adl_out_if;
  import adl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CSUM_W-1:0] checksum;
  logic              final_res;

  modport source (output valid, checksum, final_res, input ready);
  modport sink   (input valid, checksum, final_res, output ready);
endinterface

[hw/rtl/adler32_checksum.sv]
// adler32_checksum: adler-32 running checksum, up to eight bytes per word
// pipeline: an accepted word passes the lane, merge and sum registers before its result is valid
// throughput: one word per cycle while the receiver does not stall the output; the sum update closes the loop per word
// reset: low sum 1, high sum 0, pipeline empty; async active-low reset
// depends on adl_pkg, adl_if, adl_lane, adl_merge, adl_update

module adler32_checksum #(
  parameter int unsigned LANES = adl_pkg::LANES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  adl_in_if.sink     in_i,
  adl_out_if.source  out_o
);
  import adl_pkg::*;

  localparam int unsigned SSUM_W = $clog2(LANES * 255 + 1);
  localparam int unsigned WSUM_W = $clog2(LANES * (LANES + 1) / 2 * 255 + 1);

  logic              en1, en2, en3;
  logic              v1_q, v2_q;
  ctrl_t             ctrl_d, ctrl1_q, ctrl2;
  logic [CNT_W-1:0]  count;
  logic [BYTE_W-1:0] lane_byte [LANES];
  logic [PROD_W-1:0] lane_wt [LANES];
  logic [SSUM_W-1:0] byte_sum;
  logic [WSUM_W-1:0] wt_sum;

  // stage enables, each stage moves when the next one has room
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  // byte count saturates at the lane count
  assign count = ({1'b0, in_i.byte_count} > (CNT_W+1)'(LANES)) ?
                 CNT_W'(LANES) : in_i.byte_count;

  // word control with the seed halves reduced
  always_comb begin
    ctrl_d.first   = in_i.first;
    ctrl_d.last    = in_i.last;
    ctrl_d.seed_lo = reduce16(in_i.seed[HALF_W-1:0]);
    ctrl_d.seed_hi = reduce16(in_i.seed[SEED_W-1:HALF_W]);
    ctrl_d.count   = count;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i) begin
    if (en1) ctrl1_q <= ctrl_d;
  end

  // byte lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    adl_lane #(.IDX(g)) u_lane (
      .clk_i       (clk_i),
      .en_i        (en1),
      .data_word_i (in_i.data_word),
      .count_i     (count),
      .byte_o      (lane_byte[g]),
      .weighted_o  (lane_wt[g])
    );
  end

  // lane merge
  adl_merge #(
    .LANES  (LANES),
    .SSUM_W (SSUM_W),
    .WSUM_W (WSUM_W)
  ) u_merge (
    .clk_i          (clk_i),
    .en_i           (en2),
    .ctrl_i         (ctrl1_q),
    .byte_i         (lane_byte),
    .weighted_i     (lane_wt),
    .ctrl_o         (ctrl2),
    .byte_sum_o     (byte_sum),
    .weighted_sum_o (wt_sum)
  );

  // sum update and output register
  adl_update #(
    .SSUM_W (SSUM_W),
    .WSUM_W (WSUM_W)
  ) u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v2_q),
    .ctrl_i         (ctrl2),
    .byte_sum_i     (byte_sum),
    .weighted_sum_i (wt_sum),
    .en_o           (en3),
    .out_o          (out_o)
  );

endmodule

[hw/rtl/adl_lane.sv]
// adl_lane: one byte lane, picks its byte and weights it by its distance to the word end
// depends on adl_pkg

module adl_lane #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [adl_pkg::DATA_W-1:0]    data_word_i,
  input  logic [adl_pkg::CNT_W-1:0]     count_i,
  output logic [adl_pkg::BYTE_W-1:0]    byte_o,
  output logic [adl_pkg::PROD_W-1:0]    weighted_o
);
  import adl_pkg::*;

  logic [BYTE_W-1:0] raw_byte;
  logic              lane_on;
  logic [CNT_W-1:0]  weight;
  logic [BYTE_W-1:0] byte_d, byte_q;
  logic [PROD_W-1:0] weighted_d, weighted_q;

  // byte select, positions past the data word read as zero
  if (IDX < DATA_BYTES) begin : g_byte
    assign raw_byte = data_word_i[IDX*BYTE_W +: BYTE_W];
  end else begin : g_zero
    assign raw_byte = '0;
  end

  // lane is active when its position is below the byte count
  assign lane_on = ({1'b0, count_i} > (CNT_W+1)'(IDX));

  // byte i feeds the high sum (count - i) times within the word
  always_comb begin
    weight     = count_i - CNT_W'(IDX);
    byte_d     = lane_on ? raw_byte : '0;
    weighted_d = lane_on ? (PROD_W'(weight) * PROD_W'(raw_byte)) : '0;
  end

  // lane register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q     <= byte_d;
      weighted_q <= weighted_d;
    end
  end

  assign byte_o     = byte_q;
  assign weighted_o = weighted_q;

endmodule

[hw/rtl/adl_merge.sv]
// adl_merge: adds the lane results into a plain byte sum and a weighted sum
// depends on adl_pkg

module adl_merge #(
  parameter int unsigned LANES  = adl_pkg::LANES_DEF,
  parameter int unsigned SSUM_W = 8,
  parameter int unsigned WSUM_W = 8
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  adl_pkg::ctrl_t             ctrl_i,
  input  logic [adl_pkg::BYTE_W-1:0] byte_i [LANES],
  input  logic [adl_pkg::PROD_W-1:0] weighted_i [LANES],
  output adl_pkg::ctrl_t             ctrl_o,
  output logic [SSUM_W-1:0]          byte_sum_o,
  output logic [WSUM_W-1:0]          weighted_sum_o
);
  import adl_pkg::*;

  logic [SSUM_W-1:0] bsum_d, bsum_q;
  logic [WSUM_W-1:0] wsum_d, wsum_q;
  ctrl_t             ctrl_q;

  // adder tree over the lanes
  always_comb begin
    bsum_d = '0;
    wsum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      bsum_d = bsum_d + SSUM_W'(byte_i[i]);
      wsum_d = wsum_d + WSUM_W'(weighted_i[i]);
    end
  end

  // merge register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsum_q <= bsum_d;
      wsum_q <= wsum_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign ctrl_o         = ctrl_q;
  assign byte_sum_o     = bsum_q;
  assign weighted_sum_o = wsum_q;

endmodule

[hw/rtl/adl_update.sv]
// adl_update: running sums and output register of the adler-32 block
// depends on adl_pkg and adl_out_if

module adl_update #(
  parameter int unsigned SSUM_W = 8,
  parameter int unsigned WSUM_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  adl_pkg::ctrl_t    ctrl_i,
  input  logic [SSUM_W-1:0] byte_sum_i,
  input  logic [WSUM_W-1:0] weighted_sum_i,
  output logic              en_o,
  adl_out_if.source         out_o
);
  import adl_pkg::*;

  logic [HALF_W-1:0] a_d, a_q;
  logic [HALF_W-1:0] b_d, b_q;
  logic [HALF_W-1:0] base_a, base_b;
  logic [HALF_W:0]   a_sum;
  logic [WIDE_W-1:0] b_wide;
  logic [HALF_W:0]   b_fold;
  logic              load;
  logic              valid_q;
  logic [CSUM_W-1:0] csum_q;
  logic              final_q;

  // output register frees up when empty or taken
  assign en_o = !valid_q || out_o.ready;
  assign load = en_o && valid_i;

  // sums update for a whole word: a += S, b += n*a + W (mod 65521)
  always_comb begin
    base_a = ctrl_i.first ? ctrl_i.seed_lo : a_q;
    base_b = ctrl_i.first ? ctrl_i.seed_hi : b_q;

    a_sum = 17'(base_a) + 17'(byte_sum_i);
    a_d   = (a_sum >= MOD17) ? HALF_W'(a_sum - MOD17) : HALF_W'(a_sum);

    b_wide = WIDE_W'(base_b) + (WIDE_W'(ctrl_i.count) * WIDE_W'(base_a))
           + WIDE_W'(weighted_sum_i);
    // fold the bits above 2^16 back in, then one final subtract
    b_fold = (17'(b_wide[WIDE_W-1:HALF_W]) * FOLD) + 17'(b_wide[HALF_W-1:0]);
    b_d    = (b_fold >= MOD17) ? HALF_W'(b_fold - MOD17) : HALF_W'(b_fold);
  end

  // running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 16'd1;
      b_q <= '0;
    end else if (load) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      csum_q  <= {b_d, a_d};
      final_q <= ctrl_i.last;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.checksum  = csum_q;
  assign out_o.final_res = final_q;

  // sums stay fully reduced
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni) a_q < MOD16)
    else $error("low sum out of range");
  b_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni) b_q < MOD16)
    else $error("high sum out of range");
  // a loaded word always shows the new running sums
  csum_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load |=> (valid_q && csum_q == {b_q, a_q}))
    else $error("checksum does not match running sums");
  // a word may only load into a free output register
  no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid_q && !out_o.ready) |-> !load)
    else $error("output word overwritten while stalled");

endmodule

[sim/adler32_checksum_checker.sv]
// adler32_checksum_checker: watches the word and result channels, predicts each checksum
// depends on adl_pkg and the adl_in_if / adl_out_if interfaces

module adler32_checksum_checker #(
  parameter int unsigned LANES = adl_pkg::LANES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  adl_in_if           word_i,
  adl_out_if          res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import adl_pkg::*;

  localparam int unsigned CSUM_MOD = 65521;

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } adler_sums_t;

  typedef struct packed {
    logic [CSUM_W-1:0] checksum;
    logic              final_res;
  } csum_due_t;

  // running sums start at the standard values 1 and 0
  adler_sums_t run_sums = {16'd0, 16'd1};
  csum_due_t   csum_due[$];
  int unsigned csum_errors = 0;

  // fold the valid bytes of one word into the sums, lowest byte first
  function automatic adler_sums_t adler_advance(input adler_sums_t s,
                                                input logic [DATA_W-1:0] data,
                                                input logic [CNT_W-1:0] nbytes);
    int unsigned a;
    int unsigned b;
    int unsigned n;
    int unsigned lane_val;
    a = 32'(s.low);
    b = 32'(s.high);
    n = (nbytes > LANES) ? LANES : 32'(nbytes);
    for (int unsigned i = 0; i < n; i++) begin
      // lanes past the data word read as zero
      lane_val = 0;
      if (i < DATA_BYTES) lane_val = 32'(data[BYTE_W*i +: BYTE_W]);
      a = (a + lane_val) % CSUM_MOD;
      b = (b + a) % CSUM_MOD;
    end
    return {b[HALF_W-1:0], a[HALF_W-1:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    csum_errors++;
  endtask

  always @(posedge clk_i) begin
    csum_due_t   due;
    adler_sums_t start;
    if (rst_ni) begin
      // results first, so a word accepted on this edge never meets itself
      if (res_i.valid && res_i.ready) begin
        if (csum_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, checksum %h final %b",
                                    res_i.checksum, res_i.final_res));
        end else begin
          due = csum_due.pop_front();
          if (res_i.checksum !== due.checksum)
            report_mismatch($sformatf("checksum %h, expected %h",
                                      res_i.checksum, due.checksum));
          if (res_i.final_res !== due.final_res)
            report_mismatch($sformatf("final_res %b, expected %b (checksum %h)",
                                      res_i.final_res, due.final_res, due.checksum));
        end
      end

      // accepted word: optional seed load, then the byte updates
      if (word_i.valid && word_i.ready) begin
        start = run_sums;
        if (word_i.first) begin
          start.high = HALF_W'(32'(word_i.seed[SEED_W-1:HALF_W]) % CSUM_MOD);
          start.low  = HALF_W'(32'(word_i.seed[HALF_W-1:0]) % CSUM_MOD);
        end
        run_sums = adler_advance(start, word_i.data_word, word_i.byte_count);
        csum_due.push_back({run_sums, word_i.last});
      end
    end
    errors_o  <= csum_errors;
    pending_o <= csum_due.size();
  end

endmodule

[sim/adler32_checksum_test.sv]
// adler32_checksum_test: drives directed and random words into the adler-32 block
// depends on adl_pkg, adl_if, the adler32_checksum rtl and adler32_checksum_checker

module adler32_checksum_test;
  import adl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned WORD_TARGET  = 950;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  adl_in_if  in_ch ();
  adl_out_if out_ch ();

  int unsigned csum_errors;
  int unsigned csum_pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;

  adler32_checksum uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  adler32_checksum_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_i    (in_ch),
    .res_i     (out_ch),
    .errors_o  (csum_errors),
    .pending_o (csum_pending)
  );

  // 20-unit clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one word after random idle cycles, hold it until accepted
  task automatic send_word(input logic [SEED_W-1:0] seed, input logic [DATA_W-1:0] data,
                           input logic [CNT_W-1:0] nbytes, input logic first,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_word <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.seed       <= seed;
    in_ch.data_word  <= data;
    in_ch.byte_count <= nbytes;
    in_ch.first      <= first;
    in_ch.last       <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  // seeds, sometimes with halves at or above the modulus
  function automatic logic [SEED_W-1:0] pick_seed();
    logic [SEED_W-1:0] s;
    s = $urandom;
    if ($urandom_range(3) == 0) s[HALF_W-1:0] = HALF_W'($urandom_range(65535, 65521));
    if ($urandom_range(3) == 0) s[SEED_W-1:HALF_W] = HALF_W'($urandom_range(65535, 65521));
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    logic [DATA_W-1:0] d;
    case ($urandom_range(9))
      0: d = '1;
      1: d = '0;
      default: d = {$urandom, $urandom};
    endcase
    return d;
  endfunction

  // mostly legal byte counts, some zero and some above the lane count
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return CNT_W'($urandom_range(8, 1));
    if (r < 92) return '0;
    return CNT_W'($urandom_range(15, 9));
  endfunction

  // one buffer: first word seeds, last word flags the end
  task automatic send_buffer(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_word(pick_seed(), pick_data(), pick_count(), k == 0, k == len - 1);
  endtask

  task automatic run_phase(input int unsigned upto);
    while (words_sent < upto) begin
      if ($urandom_range(99) < 85)
        send_buffer($urandom_range(12, 1));
      else
        send_word(pick_seed(), pick_data(), pick_count(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
  endtask

  // sender stops until every pending checksum has come back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (csum_pending != 0);
  endtask

  // run-away guard
  initial begin
    for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("adler32_checksum_test: errors");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.seed       = '0;
    in_ch.data_word  = '0;
    in_ch.byte_count = '0;
    in_ch.first      = 1'b0;
    in_ch.last       = 1'b0;
    out_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    send_idle_pct    = 23;
    recv_idle_pct   <= 74;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // start values straight out of reset, no first word
    send_word('0, 64'h0, 4'd1, 1'b0, 1'b0);
    send_word('0, '1, 4'd8, 1'b0, 1'b0);
    // zero byte count passes the sums through
    send_word('0, '1, 4'd0, 1'b0, 1'b1);
    // seed halves at or above the modulus are reduced on load
    send_word(32'hffff_ffff, '0, 4'd0, 1'b1, 1'b0);
    send_word({16'd65521, 16'd65521}, 64'h0, 4'd1, 1'b1, 1'b0);
    send_word({16'd65520, 16'd65520}, '1, 4'd8, 1'b1, 1'b1);
    send_word({16'd65522, 16'd0}, 64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0);
    // counts past the lane count saturate
    send_word('0, 64'h0123_4567_89ab_cdef, 4'd9, 1'b0, 1'b0);
    send_word('0, 64'hfedc_ba98_7654_3210, 4'd15, 1'b0, 1'b1);
    // first and last on one word
    send_word(32'h0000_0001, 64'h0102_0304_0506_0708, 4'd8, 1'b1, 1'b1);
    send_word(32'h0000_0000, '1, 4'd15, 1'b1, 1'b1);
    // sums carry on past last; seed ignored without first
    repeat (6) send_word('1, '1, 4'd8, 1'b0, 1'b0);
    send_word(32'hffff_0000, 64'h5555_aaaa_5555_aaaa, 4'd4, 1'b1, 1'b0);
    send_word(32'h0000_ffff, 64'haaaa_5555_aaaa_5555, 4'd7, 1'b0, 1'b1);
    send_word('0, 64'h0, 4'd0, 1'b1, 1'b1);

    // random buffers, slow receiver
    run_phase(WORD_TARGET / 3);
    wait_results();

    // slow sender
    send_idle_pct  = 74;
    recv_idle_pct <= 23;
    run_phase(2 * WORD_TARGET / 3);
    wait_results();

    // full rate, opening with a long receiver hold-off to back the block up
    send_idle_pct  = 0;
    recv_idle_pct <= 0;
    hold_req      <= hold_req + 1;
    run_phase(WORD_TARGET);
    wait_results();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (csum_errors == 0)
      $display("adler32_checksum_test: clean");
    else
      $display("adler32_checksum_test: errors");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/adl_pkg.sv
hw/rtl/adl_if.sv
hw/rtl/adl_lane.sv
hw/rtl/adl_merge.sv
hw/rtl/adl_update.sv
hw/rtl/adler32_checksum.sv
sim/adler32_checksum_checker.sv
sim/adler32_checksum_test.sv
